>>> design/adfgvx_pkg.sv
`timescale 1ns / 1ps
// Shared constants, payload types and table lookups for the ADFGVX encipher unit.
// No dependencies; imported by the top level, the checker and the testbench.
package adfgvx_pkg;

    // Capacity and key sizing
    localparam int MSG_MAX   = 32;
    localparam int KEY_MAX   = 6;
    localparam int KEY_BYTES = 6;
    localparam int KEY_W     = 8 * KEY_BYTES;
    localparam int KLEN_W    = 3;

    localparam int MSG_AW  = (MSG_MAX > 1) ? $clog2(MSG_MAX) : 1;
    localparam int CNT_W   = $clog2(MSG_MAX + 1);
    localparam int POS_W   = $clog2(2 * MSG_MAX + KEY_MAX + 1);
    localparam int KIDX_W  = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
    localparam int CLEN_W  = $clog2(KEY_MAX + 1);
    localparam int COORD_W = 3;
    localparam int ENTRY_W = 2 * COORD_W;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LETTERS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH  = 2'd1;

    // 6x6 Polybius square, row major
    localparam logic [7:0] SQUARE [36] = '{
        "b", "c", "d", "e", "f", "g",
        "m", "l", "k", "j", "i", "h",
        "n", "o", "p", "q", "r", "s",
        "y", "x", "w", "v", "u", "t",
        "z", "a", "1", "2", "3", "4",
        "0", "9", "8", "7", "6", "5"
    };

    // Coordinate letters a, d, f, g, v, x
    localparam logic [6:0] LETTERS [6] = '{7'h61, 7'h64, 7'h66, 7'h67, 7'h76, 7'h78};

    typedef struct packed {
        logic [7:0] symbol;
        logic       end_of_message;
    } t_in_item;

    typedef struct packed {
        logic [6:0] cipher_letter;
        logic       final_letter;
        logic       unknown_symbol;
        logic       truncated;
    } t_out_item;

    typedef struct packed {
        logic               found;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
    } t_sq_hit;

    // Square lookup; a miss returns row/col zero (letters a,a)
    function automatic t_sq_hit sq_lookup(input logic [7:0] sym);
        t_sq_hit hit;
        hit = '0;
        for (int r = 0; r < 6; r++) begin
            for (int c = 0; c < 6; c++) begin
                if (SQUARE[r*6 + c] == sym) begin
                    hit.found = 1'b1;
                    hit.row   = COORD_W'(r);
                    hit.col   = COORD_W'(c);
                end
            end
        end
        return hit;
    endfunction

    function automatic logic [6:0] coord_letter(input logic [COORD_W-1:0] v);
        logic [6:0] l;
        case (v)
            3'd0:    l = LETTERS[0];
            3'd1:    l = LETTERS[1];
            3'd2:    l = LETTERS[2];
            3'd3:    l = LETTERS[3];
            3'd4:    l = LETTERS[4];
            3'd5:    l = LETTERS[5];
            default: l = LETTERS[0];
        endcase
        return l;
    endfunction

endpackage

>>> design/adfgvx_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module adfgvx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                         i_clk,
    input  logic                                         i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                             i_wdata,
    input  logic                                         i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                             o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read data holds while i_re is low
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/adfgvx_encipher_unit.sv
`timescale 1ns / 1ps
// ADFGVX encipher unit, top level: byte loading, key ranking and transposed read-out.
// Depends on adfgvx_pkg and adfgvx_ram.

// ---------------------------------------------------------------------------
// Message bytes come in on the input channel one transfer per cycle while the
// input is not stalled. Each byte is looked up in the fixed 6x6 square and its
// row/column pair is written to a 32-entry coordinate RAM (one entry per byte).
// Bytes beyond 32 are dropped and flag truncated; a byte missing from the square
// is stored as a,a and flags unknown_symbol. The transfer with end_of_message
// set closes the message: the input then stalls while a small sequencer ranks
// the key columns, one column per cycle (ties broken by position), and then
// reads the coordinate RAM column by column in rank order. Read-out gives one
// letter per cycle when the output is not stalled; for each visited key column
// the sequencer first loads its start position and, after the column's letters,
// sees it run out (the column holding the final letter skips that step).
// Each letter passes the RAM read register, then the output register. The RAM
// read port sets the letter rate. The input reopens once the last read has been
// issued, so the next message may load while the final letters still wait at
// the output. The two flags are the same on every letter of a run; final_letter
// marks the last. Key registers are to be written through the plain write port
// only while the block is idle; the block does not enforce this. A key_length
// of zero acts as one, values above six act as six.
// ---------------------------------------------------------------------------
module adfgvx_encipher_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  adfgvx_pkg::t_in_item                i_in_data,
    // output channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output adfgvx_pkg::t_out_item               o_out_data,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [adfgvx_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [adfgvx_pkg::KEY_W-1:0]        i_cfg_data
);
    import adfgvx_pkg::*;

    localparam logic [1:0] ST_LOAD = 2'd0;
    localparam logic [1:0] ST_RANK = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    // control state
    logic [1:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_unk, n_unk;
    logic              r_ovf, n_ovf;
    logic [KIDX_W-1:0] r_col, n_col;
    logic              r_pos_ok, n_pos_ok;
    logic [POS_W-1:0]  r_emit_cnt, n_emit_cnt;
    logic              r_rd_pend, n_rd_pend;
    logic              r_out_valid, n_out_valid;

    // payload / run data
    logic [POS_W-1:0]  r_len, n_len;
    logic              r_run_unk, n_run_unk;
    logic              r_run_ovf, n_run_ovf;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [KIDX_W-1:0] r_order [KEY_MAX];
    logic              r_rd_half, r_rd_last, r_rd_unk, r_rd_ovf;
    t_out_item         r_out;

    // configuration registers
    logic [KEY_W-1:0]  r_key;
    logic [KLEN_W-1:0] r_klen;

    // datapath signals
    logic              w_in_acc;
    logic              w_store;
    t_sq_hit           w_hit;
    logic [CLEN_W-1:0] w_cols;
    logic [7:0]        w_kb [KEY_MAX];
    logic [7:0]        w_kb_j;
    logic [KIDX_W-1:0] w_rank;
    logic              w_adv;
    logic              w_issue;
    logic              w_order_we;
    logic [ENTRY_W-1:0] w_rdata;
    logic [COORD_W-1:0] w_coord;

    assign o_in_stall  = (r_state != ST_LOAD);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_store     = (r_count < CNT_W'(MSG_MAX));
    assign w_hit       = sq_lookup(i_in_data.symbol);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // output register frees when empty or being taken
    assign w_adv = !r_out_valid || !i_out_stall;

    // effective column count
    always_comb begin
        if (r_klen == '0) begin
            w_cols = CLEN_W'(1);
        end else if ({1'b0, r_klen} > 4'(KEY_MAX)) begin
            w_cols = CLEN_W'(KEY_MAX);
        end else begin
            w_cols = CLEN_W'(r_klen);
        end
    end

    // key bytes; positions past the packed key read as zero
    always_comb begin
        for (int i = 0; i < KEY_MAX; i++) begin
            w_kb[i] = 8'(r_key >> (8 * i));
        end
    end

    // rank of column r_col among the active columns
    assign w_kb_j = w_kb[r_col];
    always_comb begin
        int cnt;
        cnt = 0;
        for (int i = 0; i < KEY_MAX; i++) begin
            if ((CLEN_W'(i) < w_cols) &&
                ((w_kb[i] < w_kb_j) || ((w_kb[i] == w_kb_j) && (KIDX_W'(i) < r_col)))) begin
                cnt = cnt + 1;
            end
        end
        w_rank = KIDX_W'(cnt);
    end

    assign w_order_we = (r_state == ST_RANK);

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_unk       = r_unk;
        n_ovf       = r_ovf;
        n_col       = r_col;
        n_pos_ok    = r_pos_ok;
        n_emit_cnt  = r_emit_cnt;
        n_len       = r_len;
        n_run_unk   = r_run_unk;
        n_run_ovf   = r_run_ovf;
        n_pos       = r_pos;
        w_issue     = 1'b0;

        unique case (r_state)
            ST_LOAD: begin
                if (w_in_acc) begin
                    if (w_store) begin
                        n_count = r_count + CNT_W'(1);
                        n_unk   = r_unk | !w_hit.found;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_in_data.end_of_message) begin
                        n_len      = POS_W'(n_count) << 1;
                        n_run_unk  = n_unk;
                        n_run_ovf  = n_ovf;
                        n_count    = '0;
                        n_unk      = 1'b0;
                        n_ovf      = 1'b0;
                        n_col      = '0;
                        n_state    = ST_RANK;
                    end
                end
            end
            ST_RANK: begin
                if (CLEN_W'(r_col) == w_cols - CLEN_W'(1)) begin
                    n_col      = '0;
                    n_pos_ok   = 1'b0;
                    n_emit_cnt = '0;
                    n_state    = ST_EMIT;
                end else begin
                    n_col = r_col + KIDX_W'(1);
                end
            end
            ST_EMIT: begin
                if (!r_pos_ok) begin
                    n_pos    = POS_W'(r_order[r_col]);
                    n_pos_ok = 1'b1;
                end else if (r_pos < r_len) begin
                    if (!r_rd_pend || w_adv) begin
                        w_issue    = 1'b1;
                        n_pos      = r_pos + POS_W'(w_cols);
                        n_emit_cnt = r_emit_cnt + POS_W'(1);
                        if (r_emit_cnt == r_len - POS_W'(1)) begin
                            n_state = ST_LOAD;
                        end
                    end
                end else begin
                    // column exhausted, move to next rank
                    n_col    = r_col + KIDX_W'(1);
                    n_pos_ok = 1'b0;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    // read pipeline and output register occupancy
    always_comb begin
        if (w_issue) begin
            n_rd_pend = 1'b1;
        end else if (w_adv) begin
            n_rd_pend = 1'b0;
        end else begin
            n_rd_pend = r_rd_pend;
        end

        if (w_adv) begin
            n_out_valid = r_rd_pend;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign w_coord = r_rd_half ? w_rdata[COORD_W-1:0] : w_rdata[ENTRY_W-1:COORD_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_count     <= '0;
            r_unk       <= 1'b0;
            r_ovf       <= 1'b0;
            r_col       <= '0;
            r_pos_ok    <= 1'b0;
            r_emit_cnt  <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
            r_key       <= '0;
            r_klen      <= KLEN_W'(6);
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_unk       <= n_unk;
            r_ovf       <= n_ovf;
            r_col       <= n_col;
            r_pos_ok    <= n_pos_ok;
            r_emit_cnt  <= n_emit_cnt;
            r_rd_pend   <= n_rd_pend;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_KEY_LETTERS: r_key  <= i_cfg_data;
                    CFG_KEY_LENGTH:  r_klen <= i_cfg_data[KLEN_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_len     <= n_len;
        r_run_unk <= n_run_unk;
        r_run_ovf <= n_run_ovf;
        r_pos     <= n_pos;
        if (w_order_we) begin
            r_order[w_rank] <= r_col;
        end
        if (w_issue) begin
            r_rd_half <= r_pos[0];
            r_rd_last <= (r_emit_cnt == r_len - POS_W'(1));
            r_rd_unk  <= r_run_unk;
            r_rd_ovf  <= r_run_ovf;
        end
        if (w_adv && r_rd_pend) begin
            r_out.cipher_letter  <= coord_letter(w_coord);
            r_out.final_letter   <= r_rd_last;
            r_out.unknown_symbol <= r_rd_unk;
            r_out.truncated      <= r_rd_ovf;
        end
    end

    // coordinate store: one entry {row, col} per stored byte
    adfgvx_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MSG_MAX)
    ) u_coord_ram (
        .i_clk   (i_clk),
        .i_we    (w_in_acc && w_store),
        .i_waddr (r_count[MSG_AW-1:0]),
        .i_wdata ({w_hit.row, w_hit.col}),
        .i_re    (w_issue),
        .i_raddr (r_pos[MSG_AW:1]),
        .o_rdata (w_rdata)
    );

    // read-out never runs past the message length
    a_emit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_emit_cnt < r_len))
        else $error("read-out counter past message length");

    // ranking stays inside the active key columns
    a_rank_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RANK) |-> (CLEN_W'(r_col) < w_cols))
        else $error("rank column out of range");

    // an end mark starts ranking with a cleared message counter
    a_eom_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_in_data.end_of_message) |=> (r_state == ST_RANK && r_count == '0))
        else $error("end of message did not start ranking");

    // a letter reaching the output register always came from an issued read
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid && !r_rd_pend) |=> !r_out_valid)
        else $error("output valid without a pending read");

endmodule

>>> tb/adfgvx_encipher_checker.sv
`timescale 1ns / 1ps
// Scoreboard for adfgvx_encipher_unit: tracks key writes and accepted bytes, predicts
// every ciphertext letter and compares each output transfer field by field.
// Depends on adfgvx_pkg for the payload and register index types.
module adfgvx_encipher_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_in_stall,
    input  adfgvx_pkg::t_in_item             i_in_data,
    input  logic                             i_out_valid,
    input  logic                             i_out_stall,
    input  adfgvx_pkg::t_out_item            i_out_data,
    input  logic                             i_cfg_we,
    input  logic [adfgvx_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [adfgvx_pkg::KEY_W-1:0]     i_cfg_data,
    output int                               o_mismatch_count,
    output int                               o_letters_pending,
    output int                               o_letters_checked
);
    import adfgvx_pkg::*;

    localparam int MSG_CAP  = 32;
    localparam int COLS_CAP = 6;
    // square row major, then the six coordinate letters
    localparam logic [8*36-1:0] GRID        = "bcdefgmlkjihnopqrsyxwvutza1234098765";
    localparam logic [8*6-1:0]  COORD_CHARS = "adfgvx";

    logic [47:0] key_reg   = '0;
    logic [2:0]  klen_reg  = 3'd6;
    logic [2:0]  coords [64];
    int          n_stored  = 0;
    bit          unk_flag  = 1'b0;
    bit          ovf_flag  = 1'b0;
    t_out_item   letters_due [$];
    int          n_fail    = 0;
    int          n_checked = 0;

    assign o_mismatch_count  = n_fail;
    assign o_letters_checked = n_checked;

    task automatic report_mismatch(input string msg);
        $display("%0t ns MISMATCH %s", $time, msg);
        n_fail++;
    endtask

    function automatic logic [7:0] grid_char(input int k);
        return GRID[8*(35-k) +: 8];
    endfunction

    function automatic logic [6:0] coord_char(input logic [2:0] v);
        return COORD_CHARS[8*(5-int'(v)) +: 7];
    endfunction

    function automatic logic [7:0] key_byte(input int i);
        return key_reg[8*i +: 8];
    endfunction

    task automatic store_byte(input logic [7:0] sym);
        int  r;
        int  c;
        bit  hit;
        r   = 0;
        c   = 0;
        hit = 1'b0;
        for (int k = 0; k < 36; k++) begin
            if (!hit && grid_char(k) == sym) begin
                r   = k / 6;
                c   = k % 6;
                hit = 1'b1;
            end
        end
        // a miss still takes a slot, as coordinates a,a
        if (!hit) unk_flag = 1'b1;
        coords[2*n_stored]     = 3'(r);
        coords[2*n_stored + 1] = 3'(c);
        n_stored++;
    endtask

    task automatic emit_ciphertext();
        int        cols;
        int        rank;
        int        n_letters;
        int        n_run;
        int        col_at_rank [COLS_CAP];
        t_out_item run [2*MSG_CAP];
        cols = int'(klen_reg);
        if (cols == 0) cols = 1;
        if (cols > COLS_CAP) cols = COLS_CAP;
        // rank by key byte, equal bytes keep key order
        for (int j = 0; j < cols; j++) begin
            rank = 0;
            for (int i = 0; i < cols; i++) begin
                if (key_byte(i) < key_byte(j) || (key_byte(i) == key_byte(j) && i < j))
                    rank++;
            end
            col_at_rank[rank] = j;
        end
        n_letters = 2 * n_stored;
        n_run     = 0;
        for (int r = 0; r < cols; r++) begin
            for (int pos = col_at_rank[r]; pos < n_letters; pos += cols) begin
                run[n_run].cipher_letter  = coord_char(coords[pos]);
                run[n_run].final_letter   = 1'b0;
                run[n_run].unknown_symbol = unk_flag;
                run[n_run].truncated      = ovf_flag;
                n_run++;
            end
        end
        run[n_run-1].final_letter = 1'b1;
        for (int k = 0; k < n_run; k++) letters_due.push_back(run[k]);
        n_stored = 0;
        unk_flag = 1'b0;
        ovf_flag = 1'b0;
    endtask

    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (!i_rst_n) begin
            key_reg  = '0;
            klen_reg = 3'd6;
            n_stored = 0;
            unk_flag = 1'b0;
            ovf_flag = 1'b0;
            letters_due.delete();
        end else begin
            // outputs first: a letter can never come from a byte of this same edge
            if (i_out_valid && !i_out_stall) begin
                if (letters_due.size() == 0) begin
                    report_mismatch($sformatf("letter %0h with nothing expected",
                                              i_out_data.cipher_letter));
                end else begin
                    want = letters_due.pop_front();
                    n_checked++;
                    if (i_out_data.cipher_letter !== want.cipher_letter)
                        report_mismatch($sformatf("cipher_letter got %0h want %0h",
                                                  i_out_data.cipher_letter,
                                                  want.cipher_letter));
                    if (i_out_data.final_letter !== want.final_letter)
                        report_mismatch($sformatf("final_letter got %0b want %0b",
                                                  i_out_data.final_letter,
                                                  want.final_letter));
                    if (i_out_data.unknown_symbol !== want.unknown_symbol)
                        report_mismatch($sformatf("unknown_symbol got %0b want %0b",
                                                  i_out_data.unknown_symbol,
                                                  want.unknown_symbol));
                    if (i_out_data.truncated !== want.truncated)
                        report_mismatch($sformatf("truncated got %0b want %0b",
                                                  i_out_data.truncated, want.truncated));
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_KEY_LETTERS: key_reg  = i_cfg_data[47:0];
                    CFG_KEY_LENGTH:  klen_reg = i_cfg_data[2:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                if (n_stored < MSG_CAP) store_byte(i_in_data.symbol);
                else ovf_flag = 1'b1;
                if (i_in_data.end_of_message) emit_ciphertext();
            end
        end
        o_letters_pending = letters_due.size();
    end

endmodule

>>> tb/adfgvx_encipher_unit_tb.sv
`timescale 1ns / 1ps
// Testbench top for adfgvx_encipher_unit: clock, reset, message and key stimulus, verdict.
// Depends on adfgvx_pkg, the block itself and adfgvx_encipher_checker.
module adfgvx_encipher_unit_tb;
    import adfgvx_pkg::*;

    // Bytes to send before the random part stops starting new key settings
    localparam int ITEM_TARGET    = 460;
    // Idle cycles after the last letter before touching the key registers or
    // ending the run: covers ranking and the RAM read.
    localparam int SETTLE_CYCLES  = 24;
    // Cycles without any transfer or register write before giving up. The
    // slowest correct stretch is the longest output stall plus ranking and latency.
    localparam int WATCHDOG_LIMIT = 4000;
    // Register indexes past the two real ones; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;
    // Characters of the square, for well-formed message bytes
    localparam logic [8*36-1:0] SQUARE_TEXT = "bcdefgmlkjihnopqrsyxwvutza1234098765";

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    t_in_item             in_data;
    logic                 out_valid;
    logic                 out_stall;
    t_out_item            out_data;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [KEY_W-1:0]     cfg_data;

    int mismatch_count;
    int letters_pending;
    int letters_checked;
    int n_items    = 0;
    int n_messages = 0;
    int n_keys     = 0;
    int quiet      = 0;
    bit burst      = 1'b0;    // when set, the byte source sends back to back

    always #5 clk = ~clk;

    adfgvx_encipher_unit u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    adfgvx_encipher_checker u_checker (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .i_in_stall        (in_stall),
        .i_in_data         (in_data),
        .i_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .i_out_data        (out_data),
        .i_cfg_we          (cfg_we),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .o_mismatch_count  (mismatch_count),
        .o_letters_pending (letters_pending),
        .o_letters_checked (letters_checked)
    );

    // Length of an idle or stall stretch: mostly short, now and then long
    function automatic int pick_stretch();
        int r;
        r = $urandom_range(99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 93) return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    // Key text is written first character first; byte 0 of the register is
    // the first key character, so the literal is byte-reversed.
    function automatic logic [47:0] key_from_text(input logic [47:0] txt);
        logic [47:0] k;
        for (int i = 0; i < 6; i++) k[8*i +: 8] = txt[8*(5-i) +: 8];
        return k;
    endfunction

    // Output side backpressure. Runs of stall and runs of no stall are picked at
    // random, and once in a while a long clean stretch so letters stream.
    initial begin : stall_source
        int r;
        int run;
        out_stall = 1'b0;
        forever begin
            r = $urandom_range(99);
            if (r < 15) begin
                out_stall = 1'b0;
                run       = $urandom_range(20, 100);
            end else if (r < 55) begin
                out_stall = 1'b1;
                run       = pick_stretch();
            end else begin
                out_stall = 1'b0;
                run       = $urandom_range(1, 4);
            end
            repeat (run) @(negedge clk);
        end
    end

    // Watchdog: any transfer, register write or reset cycle counts as progress
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
            quiet <= 0;
        end else if (quiet + 1 >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d letters outstanding",
                     WATCHDOG_LIMIT, letters_pending);
            $display("adfgvx_encipher_unit verification failed");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // One byte transfer. Entered and left at a falling edge; valid stays up
    // on return so a gapless next byte follows without a dead cycle.
    task automatic send_byte(input logic [7:0] sym, input logic eom);
        int gap;
        gap = (burst || $urandom_range(1)) ? 0 : pick_stretch();
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid               = 1'b1;
        in_data.symbol         = sym;
        in_data.end_of_message = eom;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        n_items++;
    endtask

    // A message of len bytes, end mark on the last. Noisy messages use any
    // byte value; the rest mostly stay inside the square.
    task automatic send_message(input int len, input bit noisy);
        logic [7:0] sym;
        for (int k = 0; k < len; k++) begin
            if (noisy || $urandom_range(9) == 0) sym = 8'($urandom_range(255));
            else sym = SQUARE_TEXT[8*$urandom_range(35) +: 8];
            send_byte(sym, k == len - 1);
        end
        n_messages++;
    endtask

    // Drop valid, wait until every predicted letter has come out, then give
    // the sequencer time to go idle before any register write.
    task automatic settle();
        in_valid = 1'b0;
        while (letters_pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [KEY_W-1:0] value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    initial begin : stimulus
        int          r;
        int          len;
        logic [47:0] key;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_we    = 1'b0;
        cfg_index = CFG_KEY_LETTERS;
        cfg_data  = '0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // --- directed part ---
        // Reset key: all bytes equal and six columns, so rank is key order.
        // First and last square entries, then the two byte extremes, both
        // missing from the square.
        n_keys++;
        send_byte("b", 1'b0);
        send_byte("5", 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        n_messages++;
        settle();

        // Plain word key; writes to the unused indexes must change nothing.
        // A one-byte message gives the shortest run: two letters.
        write_reg(CFG_KEY_LETTERS, KEY_W'(key_from_text("german")));
        write_reg(CFG_KEY_LENGTH, KEY_W'(6));
        write_reg(CFG_SPARE_2, '1);
        write_reg(CFG_SPARE_3, '1);
        n_keys++;
        send_byte("x", 1'b1);
        n_messages++;
        settle();

        // All-zero key with key length zero: a single column.
        write_reg(CFG_KEY_LETTERS, '0);
        write_reg(CFG_KEY_LENGTH, KEY_W'(0));
        n_keys++;
        send_byte("a", 1'b0);
        send_byte("z", 1'b0);
        send_byte("9", 1'b1);
        n_messages++;
        settle();

        // All-ones key and all-ones length: seven saturates to six, the upper
        // data bits are ignored.
        write_reg(CFG_KEY_LETTERS, '1);
        write_reg(CFG_KEY_LENGTH, '1);
        n_keys++;
        send_byte("q", 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte("0", 1'b1);
        n_messages++;
        settle();

        // Key bytes below 'a' and repeated: FF,'a',00,'a',7F,'m' on four
        // columns, so ranking uses bytes under 'a' and breaks a tie.
        write_reg(CFG_KEY_LETTERS, KEY_W'(48'h6D7F_6100_61FF));
        write_reg(CFG_KEY_LENGTH, KEY_W'(4));
        n_keys++;
        send_byte("a", 1'b0);
        send_byte("t", 1'b0);
        send_byte("t", 1'b0);
        send_byte("a", 1'b0);
        send_byte("c", 1'b0);
        send_byte("k", 1'b0);
        send_byte("7", 1'b1);
        n_messages++;

        // --- random part ---
        // Each key setting gets a few messages. Lengths lean short but a good
        // share run to capacity or past it, so bytes get dropped, sometimes
        // including the one with the end mark.
        while (n_items < ITEM_TARGET) begin
            settle();
            r = $urandom_range(99);
            if (r < 40) begin
                key = {16'($urandom_range(65535)), 32'($urandom)};
            end else if (r < 80) begin
                // narrow alphabet forces ties
                for (int i = 0; i < 6; i++) key[8*i +: 8] = 8'($urandom_range("a", "d"));
            end else begin
                for (int i = 0; i < 6; i++) begin
                    case ($urandom_range(2))
                        0:       key[8*i +: 8] = 8'h00;
                        1:       key[8*i +: 8] = 8'hFF;
                        default: key[8*i +: 8] = "a";
                    endcase
                end
            end
            write_reg(CFG_KEY_LETTERS, KEY_W'(key));
            if ($urandom_range(3) != 0)
                write_reg(CFG_KEY_LENGTH, {16'($urandom_range(65535)), 32'($urandom)});
            n_keys++;
            repeat ($urandom_range(1, 4)) begin
                burst = ($urandom_range(4) == 0);
                r     = $urandom_range(99);
                if (r < 50)      len = $urandom_range(1, 8);
                else if (r < 75) len = $urandom_range(9, 31);
                else if (r < 85) len = 32;
                else             len = $urandom_range(33, 40);
                send_message(len, $urandom_range(3) == 0);
            end
            burst = 1'b0;
        end

        // Drain: every predicted letter out, then a margin for stray ones
        in_valid = 1'b0;
        while (letters_pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("covered %0d message bytes in %0d messages over %0d key settings",
                 n_items, n_messages, n_keys);
        $display("%0d ciphertext letters checked, %0d mismatches, %0d letters missing",
                 letters_checked, mismatch_count, letters_pending);
        if (mismatch_count == 0 && letters_pending == 0) begin
            $display("adfgvx_encipher_unit verification clean");
        end else begin
            $display("adfgvx_encipher_unit verification failed");
        end
        $finish;
    end

endmodule
